>>> hw/rtl/hir_pkg.sv
// Shared types and constants for the hierarchical index reorder unit.
package hir_pkg;

  localparam int SampleW   = 32;
  localparam int PositionW = 21;
  localparam int SizeLog2W = 3;
  localparam int PassW     = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegXSize     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegYSize     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegZSize     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPassCount = 2'd3;

  localparam logic [SizeLog2W-1:0] SizeLog2Reset  = 3'd2;
  localparam logic [PassW-1:0]     PassCountReset = 5'd6;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [PositionW-1:0] position;
    logic [SampleW-1:0]   sample_out;
    logic                 last;
    logic                 beyond_end;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

endpackage

>>> hw/rtl/hir_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
interface hir_in_if;
  logic          valid;
  logic          ready;
  hir_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hir_out_if;
  logic          valid;
  logic          ready;
  hir_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hir_cfg_if;
  logic          valid;
  logic          ready;
  hir_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/hierarchical_index_reorder_unit.sv
// Hierarchical index reorder unit: maps coarse-to-fine samples to row-major positions.
// Each accepted sample is registered and appears on the result port in the next cycle.
// Throughput: one sample per cycle; the cursor update is a single step of counter logic.
// A result held by a stalled sink blocks intake only while that result is not taken.
// Reset (asynchronous, active low) loads box sizes 4x4x4 and six passes, clears the walk.
// Any register write restarts the walk from the first sample.
module hierarchical_index_reorder_unit #(
  parameter int MAX_AXIS_LOG2 = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hir_in_if.sink      in_i,
  hir_out_if.source   out_o,
  hir_cfg_if.sink     cfg_i
);

  localparam int MW = MAX_AXIS_LOG2;
  localparam int SW = $clog2(MAX_AXIS_LOG2 + 1);
  localparam int LW = (SW > hir_pkg::SizeLog2W) ? SW : hir_pkg::SizeLog2W;
  localparam int PW = (3 * MW > hir_pkg::PositionW) ? 3 * MW : hir_pkg::PositionW;

  // Configuration registers
  logic [hir_pkg::SizeLog2W-1:0] x_size_q, y_size_q, z_size_q;
  logic [hir_pkg::SizeLog2W-1:0] x_size_d, y_size_d, z_size_d;
  logic [hir_pkg::PassW-1:0]     pass_count_q, pass_count_d;

  // Walk state
  logic                      first_q, first_d;
  logic [hir_pkg::PassW-1:0] pass_q, pass_d;
  hir_pkg::axis_e            axis_q, axis_d;
  logic [SW-1:0]             stride_x_q, stride_y_q, stride_z_q;
  logic [SW-1:0]             stride_x_d, stride_y_d, stride_z_d;
  logic [MW-1:0]             cur_x_q, cur_y_q, cur_z_q;
  logic [MW-1:0]             cur_x_d, cur_y_d, cur_z_d;

  // Result register
  logic          out_valid_q, out_valid_d;
  hir_pkg::out_t out_data_q, out_data_d;

  logic          in_fire, cfg_fire;
  logic [SW-1:0] lx, ly, lz;
  logic [MW:0]   size_x, size_y, size_z;
  logic [MW:0]   sum_x, sum_y, sum_z;
  logic [PW-1:0] pos;
  logic          last, beyond;

  function automatic logic [SW-1:0] clamp_log2(logic [hir_pkg::SizeLog2W-1:0] v);
    logic [LW-1:0] w;
    w = LW'(v);
    clamp_log2 = (w > LW'(MAX_AXIS_LOG2)) ? SW'(MAX_AXIS_LOG2) : SW'(w);
  endfunction

  // First cursor value of an axis at the start of a pass
  function automatic logic [MW-1:0] start_of(logic refined, logic [SW-1:0] s);
    start_of = (!refined || s == '0) ? '0 : (MW'(1) << (s - SW'(1)));
  endfunction

  function automatic logic [SW-1:0] halve(logic refined, logic [SW-1:0] s);
    halve = (refined && s != '0) ? s - SW'(1) : s;
  endfunction

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign lx     = clamp_log2(x_size_q);
  assign ly     = clamp_log2(y_size_q);
  assign lz     = clamp_log2(z_size_q);
  assign size_x = (MW + 1)'(1) << lx;
  assign size_y = (MW + 1)'(1) << ly;
  assign size_z = (MW + 1)'(1) << lz;
  assign sum_x  = {1'b0, cur_x_q} + ((MW + 1)'(1) << stride_x_q);
  assign sum_y  = {1'b0, cur_y_q} + ((MW + 1)'(1) << stride_y_q);
  assign sum_z  = {1'b0, cur_z_q} + ((MW + 1)'(1) << stride_z_q);
  assign pos    = (PW'(cur_z_q) << ({1'b0, lx} + {1'b0, ly})) + (PW'(cur_y_q) << lx)
                + PW'(cur_x_q);

  // Register writes
  always_comb begin
    x_size_d     = x_size_q;
    y_size_d     = y_size_q;
    z_size_d     = z_size_q;
    pass_count_d = pass_count_q;
    if (cfg_fire) begin
      unique case (cfg_i.data.index)
        hir_pkg::RegXSize:     x_size_d     = cfg_i.data.data[hir_pkg::SizeLog2W-1:0];
        hir_pkg::RegYSize:     y_size_d     = cfg_i.data.data[hir_pkg::SizeLog2W-1:0];
        hir_pkg::RegZSize:     z_size_d     = cfg_i.data.data[hir_pkg::SizeLog2W-1:0];
        hir_pkg::RegPassCount: pass_count_d = cfg_i.data.data;
        default: ;
      endcase
    end
  end

  // Walk step
  always_comb begin
    first_d    = first_q;
    pass_d     = pass_q;
    axis_d     = axis_q;
    stride_x_d = stride_x_q;
    stride_y_d = stride_y_q;
    stride_z_d = stride_z_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    cur_z_d    = cur_z_q;
    last       = 1'b0;
    beyond     = 1'b0;

    if (cfg_fire) begin
      // restart with the freshly written sizes
      first_d    = 1'b0;
      pass_d     = '0;
      axis_d     = hir_pkg::AXIS_X;
      stride_x_d = clamp_log2(x_size_d);
      stride_y_d = clamp_log2(y_size_d);
      stride_z_d = clamp_log2(z_size_d);
      cur_x_d    = '0;
      cur_y_d    = '0;
      cur_z_d    = '0;
    end else if (in_fire) begin
      if (!first_q) begin
        first_d = 1'b1;
        if (pass_count_q == '0) begin
          last = 1'b1;
        end else begin
          cur_x_d = start_of(axis_q == hir_pkg::AXIS_X, stride_x_q);
          cur_y_d = start_of(axis_q == hir_pkg::AXIS_Y, stride_y_q);
          cur_z_d = start_of(axis_q == hir_pkg::AXIS_Z, stride_z_q);
        end
      end else if (pass_q >= pass_count_q) begin
        beyond = 1'b1;
      end else begin
        cur_x_d = sum_x[MW-1:0];
        if (sum_x >= size_x) begin
          cur_x_d = start_of(axis_q == hir_pkg::AXIS_X, stride_x_q);
          cur_y_d = sum_y[MW-1:0];
          if (sum_y >= size_y) begin
            cur_y_d = start_of(axis_q == hir_pkg::AXIS_Y, stride_y_q);
            cur_z_d = sum_z[MW-1:0];
            if (sum_z >= size_z) begin
              // pass done: halve the refined axis, advance to the next axis
              stride_x_d = halve(axis_q == hir_pkg::AXIS_X, stride_x_q);
              stride_y_d = halve(axis_q == hir_pkg::AXIS_Y, stride_y_q);
              stride_z_d = halve(axis_q == hir_pkg::AXIS_Z, stride_z_q);
              pass_d     = pass_q + hir_pkg::PassW'(1);
              unique case (axis_q)
                hir_pkg::AXIS_X: axis_d = hir_pkg::AXIS_Y;
                hir_pkg::AXIS_Y: axis_d = hir_pkg::AXIS_Z;
                default:         axis_d = hir_pkg::AXIS_X;
              endcase
              if (pass_d < pass_count_q) begin
                cur_x_d = start_of(axis_d == hir_pkg::AXIS_X, stride_x_d);
                cur_y_d = start_of(axis_d == hir_pkg::AXIS_Y, stride_y_d);
                cur_z_d = start_of(axis_d == hir_pkg::AXIS_Z, stride_z_d);
              end else begin
                last = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // Result register: load on intake, drop when the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_fire) begin
      out_valid_d           = 1'b1;
      out_data_d.sample_out = in_i.data.sample;
      out_data_d.last       = last;
      out_data_d.beyond_end = beyond;
      out_data_d.position   = (first_q && !beyond) ? pos[hir_pkg::PositionW-1:0] : '0;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_size_q     <= hir_pkg::SizeLog2Reset;
      y_size_q     <= hir_pkg::SizeLog2Reset;
      z_size_q     <= hir_pkg::SizeLog2Reset;
      pass_count_q <= hir_pkg::PassCountReset;
      first_q      <= 1'b0;
      pass_q       <= '0;
      axis_q       <= hir_pkg::AXIS_X;
      stride_x_q   <= clamp_log2(hir_pkg::SizeLog2Reset);
      stride_y_q   <= clamp_log2(hir_pkg::SizeLog2Reset);
      stride_z_q   <= clamp_log2(hir_pkg::SizeLog2Reset);
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      cur_z_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      x_size_q     <= x_size_d;
      y_size_q     <= y_size_d;
      z_size_q     <= z_size_d;
      pass_count_q <= pass_count_d;
      first_q      <= first_d;
      pass_q       <= pass_d;
      axis_q       <= axis_d;
      stride_x_q   <= stride_x_d;
      stride_y_q   <= stride_y_d;
      stride_z_q   <= stride_z_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      cur_z_q      <= cur_z_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

>>> bench/testbench.sv
// Self-checking bench for the hierarchical index reorder unit: random walks, stalls, restarts.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni = 1'b0;

  hir_in_if  in_if ();
  hir_out_if out_if ();
  hir_cfg_if cfg_if ();

  hierarchical_index_reorder_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Walk state; the per-axis arrays are indexed by axis_e
  int box_log2 [3];
  int stride_l2 [3];
  int cur [3];
  int pass_limit;
  int pass_no;
  bit walk_started;

  hir_pkg::in_t  sample_q [$];
  hir_pkg::out_t pending_results [$];
  int   failures = 0;
  bit   in_fire = 1'b0;
  bit   steady = 1'b0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic void restart_walk();
    walk_started = 1'b0;
    pass_no = 0;
    for (int a = 0; a < 3; a++) begin
      stride_l2[a] = box_log2[a];
      cur[a] = 0;
    end
  endfunction

  // Refined axis starts at half its stride; other axes and a unit stride start at 0.
  function automatic int axis_origin(int a);
    if (a != pass_no % 3 || stride_l2[a] == 0) return 0;
    return 1 << (stride_l2[a] - 1);
  endfunction

  function automatic void open_pass();
    for (int a = 0; a < 3; a++) cur[a] = axis_origin(a);
  endfunction

  function automatic hir_pkg::out_t walk_step(logic [hir_pkg::SampleW-1:0] smp);
    hir_pkg::out_t r;
    longint        pos;
    int            refined;
    r = '0;
    r.sample_out = smp;
    if (!walk_started) begin
      walk_started = 1'b1;
      if (pass_limit == 0) r.last = 1'b1;
      else open_pass();
    end else if (pass_no >= pass_limit) begin
      r.beyond_end = 1'b1;
    end else begin
      pos = (longint'(cur[hir_pkg::AXIS_Z])
             << (box_log2[hir_pkg::AXIS_X] + box_log2[hir_pkg::AXIS_Y]))
          + (longint'(cur[hir_pkg::AXIS_Y]) << box_log2[hir_pkg::AXIS_X])
          + cur[hir_pkg::AXIS_X];
      r.position = pos[hir_pkg::PositionW-1:0];
      // Advance x innermost, carry into y, then z; end of z closes the pass.
      cur[hir_pkg::AXIS_X] += 1 << stride_l2[hir_pkg::AXIS_X];
      if (cur[hir_pkg::AXIS_X] >= (1 << box_log2[hir_pkg::AXIS_X])) begin
        cur[hir_pkg::AXIS_X] = axis_origin(hir_pkg::AXIS_X);
        cur[hir_pkg::AXIS_Y] += 1 << stride_l2[hir_pkg::AXIS_Y];
        if (cur[hir_pkg::AXIS_Y] >= (1 << box_log2[hir_pkg::AXIS_Y])) begin
          cur[hir_pkg::AXIS_Y] = axis_origin(hir_pkg::AXIS_Y);
          cur[hir_pkg::AXIS_Z] += 1 << stride_l2[hir_pkg::AXIS_Z];
          if (cur[hir_pkg::AXIS_Z] >= (1 << box_log2[hir_pkg::AXIS_Z])) begin
            refined = pass_no % 3;
            if (stride_l2[refined] > 0) stride_l2[refined]--;
            pass_no = (pass_no + 1) % 32;
            if (pass_no < pass_limit) open_pass();
            else r.last = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // Samples in a complete stream: first sample plus the product of per-axis counts per pass.
  function automatic int stream_length(int lx, int ly, int lz, int passes);
    int lg [3];
    int s [3];
    int total;
    lg = '{lx, ly, lz};
    s = lg;
    total = 1;
    for (int p = 0; p < passes; p++) begin
      total += 1 << ((lg[0] - s[0]) + (lg[1] - s[1]) + (lg[2] - s[2]));
      if (s[p % 3] > 0) s[p % 3]--;
    end
    return total;
  endfunction

  function automatic logic [hir_pkg::SampleW-1:0] rand_sample();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Monitor: register writes, result checks, then new requests into the predictor.
  always @(posedge clk_i) begin
    hir_pkg::out_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          hir_pkg::RegXSize:
            box_log2[hir_pkg::AXIS_X] = cfg_if.data.data[hir_pkg::SizeLog2W-1:0];
          hir_pkg::RegYSize:
            box_log2[hir_pkg::AXIS_Y] = cfg_if.data.data[hir_pkg::SizeLog2W-1:0];
          hir_pkg::RegZSize:
            box_log2[hir_pkg::AXIS_Z] = cfg_if.data.data[hir_pkg::SizeLog2W-1:0];
          hir_pkg::RegPassCount: pass_limit = cfg_if.data.data;
          default: ;
        endcase
        restart_walk();
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result 0x%0h with no request pending", out_if.data);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_if.data.position);
            failures++;
          end
          if (out_if.data.sample_out !== want.sample_out) begin
            $error("sample_out: expected 0x%08h, got 0x%08h",
                   want.sample_out, out_if.data.sample_out);
            failures++;
          end
          if (out_if.data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_if.data.last);
            failures++;
          end
          if (out_if.data.beyond_end !== want.beyond_end) begin
            $error("beyond_end: expected %0b, got %0b", want.beyond_end, out_if.data.beyond_end);
            failures++;
          end
        end
      end
      in_fire = in_if.valid && in_if.ready;
      if (in_fire)
        pending_results.insert(pending_results.size(), walk_step(in_if.data.sample));
    end
  end

  // Driver and result sink: change on the falling edge, hold a request until taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || ($urandom_range(99) >= 28);
      if (!in_if.valid || in_fire) begin
        if (sample_q.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
          in_if.valid <= 1'b1;
          in_if.data <= sample_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic write_reg(logic [hir_pkg::CfgIdxW-1:0] idx,
                           logic [hir_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, data: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Size registers only keep the low bits; toggle the upper ones anyway.
  task automatic configure(int lx, int ly, int lz, int passes);
    write_reg(hir_pkg::RegXSize, {2'($urandom_range(3)), 3'(lx)});
    write_reg(hir_pkg::RegYSize, {2'($urandom_range(3)), 3'(ly)});
    write_reg(hir_pkg::RegZSize, {2'($urandom_range(3)), 3'(lz)});
    write_reg(hir_pkg::RegPassCount, 5'(passes));
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_if.valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_sample(logic [hir_pkg::SampleW-1:0] smp);
    sample_q.insert(sample_q.size(), hir_pkg::in_t'(smp));
  endtask

  task automatic push_samples(int count);
    repeat (count) queue_sample(rand_sample());
  endtask

  initial begin
    int lx, ly, lz, passes, len, count, phase, sent;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    box_log2 = '{hir_pkg::SizeLog2Reset, hir_pkg::SizeLog2Reset, hir_pkg::SizeLog2Reset};
    pass_limit = hir_pkg::PassCountReset;
    restart_walk();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings, extreme sample words
    queue_sample(32'h0000_0000);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'h5A5A_A5A5);
    drain();
    // Unit box: every stride is 1, each pass walks one cell
    configure(0, 0, 0, 2);
    push_samples(4);
    drain();
    // No passes: first sample is last, then beyond the end
    configure(7, 7, 7, 0);
    push_samples(2);
    drain();
    // Largest box, a few coarse passes, one sample past the end
    configure(7, 7, 7, 3);
    push_samples(9);
    drain();

    phase = 0;
    sent = 0;
    while (sent < 1200) begin
      if (phase == 0) begin
        lx = 0;
        ly = 1;
        lz = 0;
        passes = 31;
      end else begin
        lx = ($urandom_range(9) == 0) ? 7 : $urandom_range(3);
        ly = ($urandom_range(9) == 0) ? 7 : $urandom_range(3);
        lz = ($urandom_range(9) == 0) ? 7 : $urandom_range(3);
        passes = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(9);
      end
      steady = (phase >= 4 && phase < 7);
      configure(lx, ly, lz, passes);
      len = stream_length(lx, ly, lz, passes);
      count = (len <= 300) ? len + $urandom_range(5) : $urandom_range(150, 30);
      push_samples(count);
      sent += count;
      drain();
      phase++;
    end

    if (failures == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/hir_pkg.sv
hw/rtl/hir_if.sv
hw/rtl/hierarchical_index_reorder_unit.sv
bench/testbench.sv
